>>> rtl/dpd_pkg.sv
package dpd_pkg;

  // Widths of the angle terms built in the front (t1-t2, 2(t1-t2), t1-2t2)
  localparam int ANG_W = 35;

  // Queue between front and back
  localparam int Q_DEPTH = 4;
  localparam int Q_AW    = $clog2(Q_DEPTH);

  // Register indexes on the configuration port
  localparam logic [2:0] REG_GRAVITY      = 3'd0;
  localparam logic [2:0] REG_MASS_UPPER   = 3'd1;
  localparam logic [2:0] REG_MASS_LOWER   = 3'd2;
  localparam logic [2:0] REG_LENGTH_UPPER = 3'd3;
  localparam logic [2:0] REG_LENGTH_LOWER = 3'd4;

  // 1/(2 pi) in Q0.60, split for 32-bit partial products
  localparam logic [59:0] INV_TWO_PI = 60'd183493156455125854;
  localparam logic [31:0] INV_LO     = INV_TWO_PI[31:0];
  localparam logic [27:0] INV_HI     = INV_TWO_PI[59:32];

  localparam logic [30:0] ONE_Q30 = 31'h4000_0000;
  localparam logic [31:0] QUARTER_TURN = 32'h4000_0000;

  // Odd polynomial for sin(pi z / 2), Horner order, Q0.30
  localparam logic [30:0] SINE_COEF [6] = '{
    31'd3864, 31'd172272, 31'd5026990, 31'd85569305, 31'd693598668, 31'd1686629713
  };

  localparam logic signed [63:0] SMAX   = 64'sh7FFF_FFFF_FFFF_FFFF;
  localparam logic signed [64:0] SMAX65 = 65'sh0_7FFF_FFFF_FFFF_FFFF;

  typedef struct packed {
    logic signed [31:0] angle_upper;
    logic signed [31:0] rate_upper;
    logic signed [31:0] angle_lower;
    logic signed [31:0] rate_lower;
  } dpd_in_t;

  typedef struct packed {
    logic signed [31:0]      t1;
    logic signed [ANG_W-1:0] d;
    logic signed [ANG_W-1:0] d2;
    logic signed [ANG_W-1:0] t12;
    logic signed [31:0]      w1;
    logic signed [31:0]      w2;
  } dpd_item_t;

  typedef struct packed {
    logic [30:0] gravity;
    logic [30:0] mass_upper;
    logic [30:0] mass_lower;
    logic [30:0] length_upper;
    logic [30:0] length_lower;
  } dpd_cfg_t;

  typedef struct packed {
    logic signed [31:0] rate_upper_out;
    logic signed [31:0] accel_upper;
    logic signed [31:0] rate_lower_out;
    logic signed [31:0] accel_lower;
    logic               saturated;
  } dpd_result_t;

  typedef struct packed {
    logic               sat;
    logic signed [63:0] val;
  } dpd_fx_t;

  // Saturating add, clipped to +-(2^63-1)
  function automatic dpd_fx_t fx_add(input logic signed [63:0] a, input logic signed [63:0] b);
    logic signed [64:0] s;
    dpd_fx_t            res;
    s = {a[63], a} + {b[63], b};
    if (s > SMAX65) begin
      res.sat = 1'b1;
      res.val = SMAX;
    end else if (s < -SMAX65) begin
      res.sat = 1'b1;
      res.val = -SMAX;
    end else begin
      res.sat = 1'b0;
      res.val = s[63:0];
    end
    return res;
  endfunction

endpackage

>>> rtl/dpd_front.sv
module dpd_front import dpd_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  dpd_in_t   in_data,
  output logic      item_valid,
  input  logic      item_ready,
  output dpd_item_t item
);

  logic      valid_r;
  dpd_item_t item_r;
  dpd_item_t item_nxt;

  assign in_ready   = !valid_r || item_ready;
  assign item_valid = valid_r;
  assign item       = item_r;

  // Angle combinations needed by the trig units
  always_comb begin
    logic signed [ANG_W-1:0] t1x;
    logic signed [ANG_W-1:0] t2x;
    t1x          = ANG_W'(in_data.angle_upper);
    t2x          = ANG_W'(in_data.angle_lower);
    item_nxt.t1  = in_data.angle_upper;
    item_nxt.d   = t1x - t2x;
    item_nxt.d2  = (t1x - t2x) <<< 1;
    item_nxt.t12 = t1x - (t2x <<< 1);
    item_nxt.w1  = in_data.rate_upper;
    item_nxt.w2  = in_data.rate_lower;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      item_r <= item_nxt;
    end
  end

endmodule

>>> rtl/dpd_queue.sv
module dpd_queue import dpd_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push_valid,
  output logic      push_ready,
  input  dpd_item_t push_item,
  output logic      pop_valid,
  input  logic      pop,
  output dpd_item_t pop_item
);

  dpd_item_t       mem_r [Q_DEPTH];
  logic [Q_AW-1:0] wr_ptr_r, rd_ptr_r;
  logic [Q_AW:0]   count_r;
  logic            do_push, do_pop;

  assign push_ready = (count_r != Q_DEPTH[Q_AW:0]);
  assign pop_valid  = (count_r != '0);
  assign pop_item   = mem_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop && pop_valid;

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (do_pop)  rd_ptr_r <= rd_ptr_r + 1'b1;
      if (do_push && !do_pop) count_r <= count_r + 1'b1;
      else if (do_pop && !do_push) count_r <= count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

>>> rtl/dpd_mul.sv
module dpd_mul import dpd_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  logic               clk,
  input  logic               en,
  input  logic signed [63:0] a_i,
  input  logic signed [63:0] b_i,
  output logic signed [63:0] p_o,
  output logic               sat_o
);

  logic [63:0]  ma_r, mb_r;
  logic         neg1_r, neg2_r;
  logic [63:0]  pp00_r, pp01_r, pp10_r, pp11_r;
  logic [127:0] prod;
  logic [63:0]  r;
  logic         ovf;

  // Final sum, scaling and saturation
  always_comb begin
    prod = {64'b0, pp00_r} + ({64'b0, pp01_r} << 32) + ({64'b0, pp10_r} << 32)
         + ({64'b0, pp11_r} << 64);
    r    = prod[FRAC_BITS +: 64];
    ovf  = (|prod[127:64+FRAC_BITS]) || r[63];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      // magnitudes
      ma_r   <= a_i[63] ? 64'(-a_i) : 64'(a_i);
      mb_r   <= b_i[63] ? 64'(-b_i) : 64'(b_i);
      neg1_r <= a_i[63] ^ b_i[63];
      // partial products
      pp00_r <= ma_r[31:0]  * mb_r[31:0];
      pp01_r <= ma_r[31:0]  * mb_r[63:32];
      pp10_r <= ma_r[63:32] * mb_r[31:0];
      pp11_r <= ma_r[63:32] * mb_r[63:32];
      neg2_r <= neg1_r;
      // result
      sat_o  <= ovf;
      if (ovf) p_o <= neg2_r ? -SMAX : SMAX;
      else     p_o <= neg2_r ? -$signed(r) : $signed(r);
    end
  end

endmodule

>>> rtl/dpd_sincos.sv
module dpd_sincos import dpd_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  logic                    clk,
  input  logic                    en,
  input  logic signed [ANG_W-1:0] angle_i,
  input  logic                    cos_i,
  output logic signed [63:0]      val_o
);

  localparam int HS = 5;

  logic [ANG_W-1:0] mag_r;
  logic             neg1_r, neg2_r;
  logic [63:0]      pp0_r;
  logic [59:0]      pp1_r;
  logic [34:0]      pp2_r;
  logic [30:0]      pp3_r;
  logic [95:0]      prod;
  logic [31:0]      turns, phase_r, ph;
  logic [30:0]      rem, z_c;
  logic [30:0]      z4_r, s5_r, z5_r;
  logic [1:0]       q4_r, q5_r;
  logic [61:0]      zz;
  logic [30:0]      p_h_r [HS];
  logic [30:0]      s_h_r [HS];
  logic [30:0]      z_h_r [HS];
  logic [1:0]       q_h_r [HS];
  logic [30:0]      p_h_nxt [HS];
  logic [61:0]      pz;
  logic [30:0]      pz_r, clip;
  logic [1:0]       q11_r;
  logic [63:0]      v;

  // Angle to turns, then quadrant fold
  always_comb begin
    prod  = {32'b0, pp0_r} + ({36'b0, pp1_r} << 32) + ({61'b0, pp2_r} << 32)
          + ({65'b0, pp3_r} << 64);
    turns = prod[FRAC_BITS+28 +: 32];
    ph    = phase_r + (cos_i ? QUARTER_TURN : 32'd0);
    rem   = {1'b0, ph[29:0]};
    z_c   = ph[30] ? ONE_Q30 - rem : rem;
    zz    = z4_r * z4_r;
  end

  // Horner steps, one multiply each
  always_comb begin
    logic [61:0] t;
    for (int j = 0; j < HS; j++) begin
      if (j == 0) t = SINE_COEF[0] * s5_r;
      else        t = p_h_r[j-1] * s_h_r[j-1];
      p_h_nxt[j] = SINE_COEF[j+1] - t[60:30];
    end
    pz   = p_h_r[HS-1] * z_h_r[HS-1];
    clip = (pz_r > ONE_Q30) ? ONE_Q30 : pz_r;
    v    = {33'b0, clip} >> (30 - FRAC_BITS);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      mag_r   <= angle_i[ANG_W-1] ? ANG_W'(-angle_i) : ANG_W'(angle_i);
      neg1_r  <= angle_i[ANG_W-1];
      pp0_r   <= mag_r[31:0] * INV_LO;
      pp1_r   <= mag_r[31:0] * INV_HI;
      pp2_r   <= mag_r[ANG_W-1:32] * INV_LO;
      pp3_r   <= mag_r[ANG_W-1:32] * INV_HI;
      neg2_r  <= neg1_r;
      phase_r <= neg2_r ? 32'(-turns) : turns;
      z4_r    <= z_c;
      q4_r    <= ph[31:30];
      s5_r    <= zz[60:30];
      z5_r    <= z4_r;
      q5_r    <= q4_r;
      for (int j = 0; j < HS; j++) begin
        p_h_r[j] <= p_h_nxt[j];
        s_h_r[j] <= (j == 0) ? s5_r : s_h_r[j-1];
        z_h_r[j] <= (j == 0) ? z5_r : z_h_r[j-1];
        q_h_r[j] <= (j == 0) ? q5_r : q_h_r[j-1];
      end
      pz_r    <= pz[60:30];
      q11_r   <= q_h_r[HS-1];
      val_o   <= q11_r[1] ? -$signed(v) : $signed(v);
    end
  end

endmodule

>>> rtl/dpd_div.sv
module dpd_div import dpd_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  logic               clk,
  input  logic               en,
  input  logic signed [63:0] num_i,
  input  logic signed [63:0] den_i,
  output logic signed [31:0] quo_o,
  output logic               sat_o
);

  localparam int QB = 33;
  localparam int SH = QB - FRAC_BITS;

  typedef struct packed {
    logic [63:0]   rem;
    logic [QB-1:0] bits;
    logic [QB-1:0] q;
    logic [63:0]   md;
    logic          neg;
    logic          nneg;
    logic          zero;
    logic          nz;
    logic          ovf;
  } div_st_t;

  logic [63:0] mn_r, md_r;
  logic        neg_r, nneg_r;
  div_st_t     init_r;
  div_st_t     st_r   [QB];
  div_st_t     st_nxt [QB];
  div_st_t     fin;
  logic [QB-1:0] lim;

  // One quotient bit per stage
  always_comb begin
    div_st_t     cur;
    logic [64:0] r2;
    for (int k = 0; k < QB; k++) begin
      cur = (k == 0) ? init_r : st_r[k-1];
      r2  = {cur.rem, cur.bits[QB-1]};
      st_nxt[k]      = cur;
      st_nxt[k].bits = cur.bits << 1;
      if (r2 >= {1'b0, cur.md}) begin
        st_nxt[k].rem = 64'(r2 - {1'b0, cur.md});
        st_nxt[k].q   = {cur.q[QB-2:0], 1'b1};
      end else begin
        st_nxt[k].rem = r2[63:0];
        st_nxt[k].q   = {cur.q[QB-2:0], 1'b0};
      end
    end
    fin = st_r[QB-1];
    lim = fin.neg ? QB'(33'h0_8000_0000) : QB'(33'h0_7FFF_FFFF);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      // magnitudes and signs
      mn_r   <= num_i[63] ? 64'(-num_i) : 64'(num_i);
      md_r   <= den_i[63] ? 64'(-den_i) : 64'(den_i);
      neg_r  <= num_i[63] ^ den_i[63];
      nneg_r <= num_i[63];
      // overflow check and initial remainder
      init_r.rem  <= mn_r >> SH;
      init_r.bits <= {mn_r[SH-1:0], {FRAC_BITS{1'b0}}};
      init_r.q    <= '0;
      init_r.md   <= md_r;
      init_r.neg  <= neg_r;
      init_r.nneg <= nneg_r;
      init_r.zero <= (md_r == '0);
      init_r.nz   <= (mn_r != '0);
      init_r.ovf  <= ((mn_r >> SH) >= md_r);
      for (int k = 0; k < QB; k++) begin
        st_r[k] <= st_nxt[k];
      end
      // sign and clipping
      if (fin.zero) begin
        sat_o <= fin.nz;
        if (!fin.nz)       quo_o <= '0;
        else if (fin.nneg) quo_o <= 32'sh8000_0000;
        else               quo_o <= 32'sh7FFF_FFFF;
      end else if (fin.ovf || (fin.q > lim)) begin
        sat_o <= 1'b1;
        quo_o <= fin.neg ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
      end else begin
        sat_o <= 1'b0;
        quo_o <= fin.neg ? -$signed(fin.q[31:0]) : $signed(fin.q[31:0]);
      end
    end
  end

endmodule

>>> rtl/dpd_back.sv
module dpd_back import dpd_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  dpd_cfg_t    cfg_i,
  input  logic        item_valid_i,
  input  dpd_item_t   item_i,
  output logic        item_pop_o,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output dpd_result_t out_data_o
);

  // Stage 0 register, first products at stage 3, trig at stage 12, divide from stage 20
  localparam int LAT = 56;

  logic           en;
  logic [LAT:0]   vld_r;

  logic signed [31:0]      t1_r, w1_r, w2_r;
  logic signed [ANG_W-1:0] d_r, d2_r, t12_r;

  logic signed [63:0] g64, m2_64, l1_64, l2_64, mm64, ms64, w1_64, w2_64;
  logic signed [63:0] s1, c1, sdr, cd, s12, c2d, sd2;
  logic signed [63:0] w1sq, w2sq, w1l1, w2l2, w1ms, w2m2, gm, mg, gs;
  logic signed [63:0] p, q, sdm, x1, gc, y, nc, r, den1, den2, num2;
  logic               w1sq_s, w2sq_s, w1l1_s, w2l2_s, w1ms_s, w2m2_s;
  logic               p_s, q_s, sdm_s, x1_s, gc_s, y_s, nc_s, r_s, den1_s, den2_s, num2_s;
  logic signed [31:0] a1, a2;
  logic               a1_s, a2_s;

  logic signed [63:0] w1l1_d [6];
  logic signed [63:0] w2l2_d [9];
  logic signed [63:0] w1ms_d [6];
  logic signed [63:0] w2m2_d [3];
  logic signed [63:0] sd2_d  [5];
  logic signed [63:0] pq_d   [3];
  logic signed [31:0] ru_d   [LAT];
  logic signed [31:0] rl_d   [LAT];
  logic               sat_d  [LAT];
  logic signed [63:0] sdm_r, y_r, den1_r, den2_r;

  dpd_fx_t            denc_r, pq_r, rsum_r, uw_r, v_r, num1_r;
  logic [LAT-1:0]     flags;

  assign en          = !vld_r[LAT] || out_ready_i;
  assign item_pop_o  = en && item_valid_i;
  assign out_valid_o = vld_r[LAT];

  // Operands
  assign g64   = $signed({33'b0, cfg_i.gravity});
  assign m2_64 = $signed({33'b0, cfg_i.mass_lower});
  assign l1_64 = $signed({33'b0, cfg_i.length_upper});
  assign l2_64 = $signed({33'b0, cfg_i.length_lower});
  assign mm64  = $signed({32'b0, cfg_i.mass_upper, 1'b0}) + $signed({33'b0, cfg_i.mass_lower});
  assign ms64  = $signed({33'b0, cfg_i.mass_upper}) + $signed({33'b0, cfg_i.mass_lower});
  assign w1_64 = 64'(w1_r);
  assign w2_64 = 64'(w2_r);
  assign sd2   = sdr <<< 1;

  // Valid pipeline
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[LAT-1:0], item_valid_i};
    end
  end

  // Trig units
  dpd_sincos #(.FRAC_BITS(FRAC_BITS)) u_s1  (.clk, .en, .angle_i(ANG_W'(t1_r)), .cos_i(1'b0),
                                             .val_o(s1));
  dpd_sincos #(.FRAC_BITS(FRAC_BITS)) u_c1  (.clk, .en, .angle_i(ANG_W'(t1_r)), .cos_i(1'b1),
                                             .val_o(c1));
  dpd_sincos #(.FRAC_BITS(FRAC_BITS)) u_sd  (.clk, .en, .angle_i(d_r), .cos_i(1'b0), .val_o(sdr));
  dpd_sincos #(.FRAC_BITS(FRAC_BITS)) u_cd  (.clk, .en, .angle_i(d_r), .cos_i(1'b1), .val_o(cd));
  dpd_sincos #(.FRAC_BITS(FRAC_BITS)) u_s12 (.clk, .en, .angle_i(t12_r), .cos_i(1'b0), .val_o(s12));
  dpd_sincos #(.FRAC_BITS(FRAC_BITS)) u_c2d (.clk, .en, .angle_i(d2_r), .cos_i(1'b1), .val_o(c2d));

  // Configuration-only products
  dpd_mul #(.FRAC_BITS(FRAC_BITS)) u_gm (.clk, .en(1'b1), .a_i(g64), .b_i(mm64), .p_o(gm),
                                         .sat_o());
  dpd_mul #(.FRAC_BITS(FRAC_BITS)) u_mg (.clk, .en(1'b1), .a_i(m2_64), .b_i(g64), .p_o(mg),
                                         .sat_o());
  dpd_mul #(.FRAC_BITS(FRAC_BITS)) u_gs (.clk, .en(1'b1), .a_i(g64), .b_i(ms64), .p_o(gs),
                                         .sat_o());

  // Rate terms, stages 0 to 9
  dpd_mul #(.FRAC_BITS(FRAC_BITS)) u_w1sq (.clk, .en, .a_i(w1_64), .b_i(w1_64), .p_o(w1sq),
                                           .sat_o(w1sq_s));
  dpd_mul #(.FRAC_BITS(FRAC_BITS)) u_w2sq (.clk, .en, .a_i(w2_64), .b_i(w2_64), .p_o(w2sq),
                                           .sat_o(w2sq_s));
  dpd_mul #(.FRAC_BITS(FRAC_BITS)) u_w1l1 (.clk, .en, .a_i(w1sq), .b_i(l1_64), .p_o(w1l1),
                                           .sat_o(w1l1_s));
  dpd_mul #(.FRAC_BITS(FRAC_BITS)) u_w2l2 (.clk, .en, .a_i(w2sq), .b_i(l2_64), .p_o(w2l2),
                                           .sat_o(w2l2_s));
  dpd_mul #(.FRAC_BITS(FRAC_BITS)) u_w1ms (.clk, .en, .a_i(w1l1), .b_i(ms64), .p_o(w1ms),
                                           .sat_o(w1ms_s));
  dpd_mul #(.FRAC_BITS(FRAC_BITS)) u_w2m2 (.clk, .en, .a_i(w2l2), .b_i(m2_64), .p_o(w2m2),
                                           .sat_o(w2m2_s));

  // Products with trig values, stage 12 to 15
  dpd_mul #(.FRAC_BITS(FRAC_BITS)) u_p   (.clk, .en, .a_i(gm), .b_i(s1), .p_o(p), .sat_o(p_s));
  dpd_mul #(.FRAC_BITS(FRAC_BITS)) u_q   (.clk, .en, .a_i(mg), .b_i(s12), .p_o(q), .sat_o(q_s));
  dpd_mul #(.FRAC_BITS(FRAC_BITS)) u_sdm (.clk, .en, .a_i(sd2), .b_i(m2_64), .p_o(sdm),
                                          .sat_o(sdm_s));
  dpd_mul #(.FRAC_BITS(FRAC_BITS)) u_x1  (.clk, .en, .a_i(w1l1_d[5]), .b_i(cd), .p_o(x1),
                                          .sat_o(x1_s));
  dpd_mul #(.FRAC_BITS(FRAC_BITS)) u_gc  (.clk, .en, .a_i(gs), .b_i(c1), .p_o(gc), .sat_o(gc_s));
  dpd_mul #(.FRAC_BITS(FRAC_BITS)) u_y   (.clk, .en, .a_i(w2m2_d[2]), .b_i(cd), .p_o(y),
                                          .sat_o(y_s));
  dpd_mul #(.FRAC_BITS(FRAC_BITS)) u_nc  (.clk, .en, .a_i(m2_64), .b_i(c2d), .p_o(nc),
                                          .sat_o(nc_s));

  // Stage 16 to 20
  dpd_mul #(.FRAC_BITS(FRAC_BITS)) u_r    (.clk, .en, .a_i(sdm_r), .b_i(rsum_r.val), .p_o(r),
                                           .sat_o(r_s));
  dpd_mul #(.FRAC_BITS(FRAC_BITS)) u_den1 (.clk, .en, .a_i(l1_64), .b_i(denc_r.val), .p_o(den1),
                                           .sat_o(den1_s));
  dpd_mul #(.FRAC_BITS(FRAC_BITS)) u_den2 (.clk, .en, .a_i(l2_64), .b_i(denc_r.val), .p_o(den2),
                                           .sat_o(den2_s));
  dpd_mul #(.FRAC_BITS(FRAC_BITS)) u_num2 (.clk, .en, .a_i(sd2_d[4]), .b_i(v_r.val), .p_o(num2),
                                           .sat_o(num2_s));

  // Dividers, stage 20 to 56
  dpd_div #(.FRAC_BITS(FRAC_BITS)) u_div1 (.clk, .en, .num_i(num1_r.val), .den_i(den1_r),
                                           .quo_o(a1), .sat_o(a1_s));
  dpd_div #(.FRAC_BITS(FRAC_BITS)) u_div2 (.clk, .en, .num_i(num2), .den_i(den2_r),
                                           .quo_o(a2), .sat_o(a2_s));

  // Saturation events by the stage that shows them
  always_comb begin
    flags     = '0;
    flags[3]  = w1sq_s | w2sq_s;
    flags[6]  = w1l1_s | w2l2_s;
    flags[9]  = w1ms_s | w2m2_s;
    flags[15] = p_s | q_s | sdm_s | x1_s | gc_s | y_s | nc_s;
    flags[16] = denc_r.sat | pq_r.sat | rsum_r.sat | uw_r.sat;
    flags[17] = v_r.sat;
    flags[19] = r_s | den1_s | den2_s;
    flags[20] = num1_r.sat | num2_s;
  end

  // Datapath registers, delay lines and sums
  always_ff @(posedge clk) begin
    if (en) begin
      t1_r  <= item_i.t1;
      d_r   <= item_i.d;
      d2_r  <= item_i.d2;
      t12_r <= item_i.t12;
      w1_r  <= item_i.w1;
      w2_r  <= item_i.w2;

      w1l1_d[0] <= w1l1;
      for (int i = 1; i < 6; i++) w1l1_d[i] <= w1l1_d[i-1];
      w2l2_d[0] <= w2l2;
      for (int i = 1; i < 9; i++) w2l2_d[i] <= w2l2_d[i-1];
      w1ms_d[0] <= w1ms;
      for (int i = 1; i < 6; i++) w1ms_d[i] <= w1ms_d[i-1];
      w2m2_d[0] <= w2m2;
      for (int i = 1; i < 3; i++) w2m2_d[i] <= w2m2_d[i-1];
      sd2_d[0] <= sd2;
      for (int i = 1; i < 5; i++) sd2_d[i] <= sd2_d[i-1];

      denc_r <= fx_add(mm64, -nc);
      pq_r   <= fx_add(-p, -q);
      rsum_r <= fx_add(w2l2_d[8], x1);
      uw_r   <= fx_add(w1ms_d[5], gc);
      sdm_r  <= sdm;
      y_r    <= y;
      v_r    <= fx_add(uw_r.val, y_r);

      pq_d[0] <= pq_r.val;
      for (int i = 1; i < 3; i++) pq_d[i] <= pq_d[i-1];
      num1_r <= fx_add(pq_d[2], -r);
      den1_r <= den1;
      den2_r <= den2;

      ru_d[0]  <= w1_r;
      rl_d[0]  <= w2_r;
      sat_d[0] <= flags[0];
      for (int i = 1; i < LAT; i++) begin
        ru_d[i]  <= ru_d[i-1];
        rl_d[i]  <= rl_d[i-1];
        sat_d[i] <= sat_d[i-1] | flags[i];
      end
    end
  end

  // Result beat
  always_comb begin
    out_data_o.rate_upper_out = ru_d[LAT-1];
    out_data_o.accel_upper    = a1;
    out_data_o.rate_lower_out = rl_d[LAT-1];
    out_data_o.accel_lower    = a2;
    out_data_o.saturated      = sat_d[LAT-1] | a1_s | a2_s;
  end

endmodule

>>> rtl/double_pendulum_derivative.sv
// An accepted input beat passes one front register, one queue slot, then the back pipeline
// set by the trig units, the product chain and the two 33-step dividers.
// Throughput: one beat per cycle; a stalled output holds the back pipeline.
// Reset: clears all valid bits and the queue, and loads the register defaults.
module double_pendulum_derivative import dpd_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  logic         clk,
  input  logic         rst_n,
  // tdata: angle_upper[31:0], rate_upper[63:32], angle_lower[95:64], rate_lower[127:96]
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [127:0] in_tdata,
  // tdata: rate_upper_out[31:0], accel_upper[63:32], rate_lower_out[95:64],
  //        accel_lower[127:96]
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [127:0] out_tdata,
  // tuser: saturated[0]
  output logic         out_tuser,
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [2:0]   cfg_index,
  input  logic [30:0]  cfg_data
);

  localparam int GSH = (FRAC_BITS >= 16) ? FRAC_BITS - 16 : 16 - FRAC_BITS;
  localparam logic [30:0] GRAV_RST = (FRAC_BITS >= 16) ? 31'(642908 << GSH)
                                                       : 31'(642908 >> GSH);
  localparam logic [30:0] ONE_RST  = 31'(1) << FRAC_BITS;

  dpd_cfg_t    cfg_r;
  dpd_in_t     in_fields;
  dpd_item_t   fr_item, q_item;
  logic        fr_valid, q_push_ready, q_valid, q_pop;
  dpd_result_t res;

  assign cfg_ready = 1'b1;

  // Register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.gravity      <= GRAV_RST;
      cfg_r.mass_upper   <= ONE_RST;
      cfg_r.mass_lower   <= ONE_RST;
      cfg_r.length_upper <= ONE_RST;
      cfg_r.length_lower <= ONE_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_GRAVITY:      cfg_r.gravity      <= cfg_data;
        REG_MASS_UPPER:   cfg_r.mass_upper   <= cfg_data;
        REG_MASS_LOWER:   cfg_r.mass_lower   <= cfg_data;
        REG_LENGTH_UPPER: cfg_r.length_upper <= cfg_data;
        REG_LENGTH_LOWER: cfg_r.length_lower <= cfg_data;
        default: ;
      endcase
    end
  end

  // Unpack input beat
  always_comb begin
    in_fields.angle_upper = in_tdata[31:0];
    in_fields.rate_upper  = in_tdata[63:32];
    in_fields.angle_lower = in_tdata[95:64];
    in_fields.rate_lower  = in_tdata[127:96];
  end

  dpd_front u_front (
    .clk, .rst_n,
    .in_valid(in_tvalid), .in_ready(in_tready), .in_data(in_fields),
    .item_valid(fr_valid), .item_ready(q_push_ready), .item(fr_item)
  );

  dpd_queue u_queue (
    .clk, .rst_n,
    .push_valid(fr_valid), .push_ready(q_push_ready), .push_item(fr_item),
    .pop_valid(q_valid), .pop(q_pop), .pop_item(q_item)
  );

  dpd_back #(.FRAC_BITS(FRAC_BITS)) u_back (
    .clk, .rst_n, .cfg_i(cfg_r),
    .item_valid_i(q_valid), .item_i(q_item), .item_pop_o(q_pop),
    .out_valid_o(out_tvalid), .out_ready_i(out_tready), .out_data_o(res)
  );

  // Pack result beat
  assign out_tdata = {res.accel_lower, res.rate_lower_out, res.accel_upper, res.rate_upper_out};
  assign out_tuser = res.saturated;

endmodule
